// ===== src/tvsc_pkg.sv =====
package tvsc_pkg;

   // Field widths
   localparam int OP_W        = 2;
   localparam int SIZE_W      = 32;
   localparam int STRIDE_W    = 48;
   localparam int DATA_W      = 64;
   localparam int HALF_W      = 32;
   localparam int DIM_INDEX_W = 4;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_APPEND_OLD = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_NEW = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

   // Datapath commands
   typedef enum logic [3:0] {
      DP_NOP,
      DP_APPEND_OLD,
      DP_APPEND_NEW,
      DP_SCAN_INIT,
      DP_SCAN_STEP,
      DP_PTR_LAST,
      DP_LOAD_BASE,
      DP_MUL,
      DP_TEL_WB,
      DP_BUF_WR,
      DP_BUF_ACC,
      DP_VEL_WB,
      DP_CONTIG_INIT,
      DP_PTR_ZERO,
      DP_EMIT
   } dp_code_type;

   // Multiplier operand pairs
   typedef enum logic [2:0] {
      SEL_TEL_SIZE,
      SEL_TEL_BASE,
      SEL_VEL_BASE,
      SEL_VEL_NEW,
      SEL_VEL_NEW1
   } mul_sel_type;

   // Where emitted strides come from
   typedef enum logic [1:0] {
      KIND_FAIL,
      KIND_ONES,
      KIND_OLD,
      KIND_BUF
   } emit_kind_type;

   typedef struct packed {
      dp_code_type   code;
      mul_sel_type   sel;
      emit_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic ovf;
      logic old_zero;
      logic scan_last;
      logic any_zero;
      logic same;
      logic last_dim;
      logic cur_one;
      logic vd_valid;
      logic vd_one;
      logic lt_vt;
      logic new_one;
      logic vel_eq_tel;
      logic mul_done;
      logic stride_ne;
      logic out_free;
      logic emit_end;
   } dp_sts_type;

endpackage

// ===== src/tvsc_if.sv =====
interface tvsc_req_if;
   logic                             valid;
   logic                             ready;
   logic [tvsc_pkg::OP_W-1:0]        op;
   logic [tvsc_pkg::SIZE_W-1:0]      dim_size;
   logic [tvsc_pkg::STRIDE_W-1:0]    dim_stride;

   modport source (output valid, op, dim_size, dim_stride, input ready);
   modport sink   (input valid, op, dim_size, dim_stride, output ready);
endinterface

interface tvsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ok;
   logic                             no_dims;
   logic [tvsc_pkg::DIM_INDEX_W-1:0] dim_index;
   logic [tvsc_pkg::DATA_W-1:0]      stride_out;
   logic                             end_of_list;

   modport source (output valid, ok, no_dims, dim_index, stride_out, end_of_list,
                   input ready);
   modport sink   (input valid, ok, no_dims, dim_index, stride_out, end_of_list,
                   output ready);
endinterface

// ===== src/tvsc_mul.sv =====
module tvsc_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tvsc_pkg::DATA_W-1:0] a,
   input  logic [tvsc_pkg::DATA_W-1:0] b,
   output logic                        done,
   output logic [tvsc_pkg::DATA_W-1:0] p
);

   localparam int W = tvsc_pkg::DATA_W;
   localparam int H = tvsc_pkg::HALF_W;

   // partial product order: low x low, high x low, low x high
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_HL = 2'd1;
   localparam logic [1:0] STEP_LH = 2'd2;

   logic [W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [H-1:0] op_x, op_y;
   logic [W-1:0] pp;

   // operand halves for this step
   always_comb begin
      case (step_ff)
         STEP_LL: begin
            op_x = a_ff[H-1:0];
            op_y = b_ff[H-1:0];
         end
         STEP_HL: begin
            op_x = a_ff[W-1:H];
            op_y = b_ff[H-1:0];
         end
         default: begin
            op_x = a_ff[H-1:0];
            op_y = b_ff[W-1:H];
         end
      endcase
   end

   assign pp = op_x * op_y;

   // accumulate low 64 bits of the product
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         step_in = STEP_LL;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = (step_ff == STEP_LL) ? pp : acc_ff + (pp << H);
         step_in = step_ff + 2'd1;
         if (step_ff == STEP_LH) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

// ===== src/tvsc_dp.sv =====
module tvsc_dp #(
   parameter int MAX_RANK = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tvsc_pkg::dp_cmd_type          cmd,
   output tvsc_pkg::dp_sts_type          sts,
   input  logic [tvsc_pkg::SIZE_W-1:0]   dim_size,
   input  logic [tvsc_pkg::STRIDE_W-1:0] dim_stride,
   tvsc_rsp_if.source                    rsp
);

   localparam int CNT_W = $clog2(MAX_RANK + 1);
   localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int SW    = tvsc_pkg::SIZE_W;
   localparam int TW    = tvsc_pkg::STRIDE_W;
   localparam int DW    = tvsc_pkg::DATA_W;

   // dimension lists and stride results
   logic [SW-1:0] old_sizes_ff   [MAX_RANK];
   logic [TW-1:0] old_strides_ff [MAX_RANK];
   logic [SW-1:0] new_sizes_ff   [MAX_RANK];
   logic [DW-1:0] strides_ff     [MAX_RANK];

   logic [CNT_W-1:0] old_cnt_ff, old_cnt_in, new_cnt_ff, new_cnt_in;
   logic [CNT_W-1:0] vd_cnt_ff, vd_cnt_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             ovf_ff, ovf_in;
   logic             any_zero_ff, any_zero_in, same_ff, same_in;
   logic             last_dim_ff, last_dim_in;
   logic [TW-1:0]    base_ff, base_in;
   logic [DW-1:0]    telems_ff, telems_in, velems_ff, velems_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic                             rsp_no_dims_ff, rsp_no_dims_in;
   logic [tvsc_pkg::DIM_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DW-1:0]                    rsp_stride_ff, rsp_stride_in;
   logic                             rsp_end_ff, rsp_end_in;

   logic             old_wr_en, new_wr_en, strides_wr_en;
   logic [DW-1:0]    strides_wr_data;
   logic [IDX_W-1:0] old_wr_idx, new_wr_idx, vd_idx, new_rd_idx;
   logic [CNT_W-1:0] vd_m1, old_m1, ptr_plus;
   logic [SW-1:0]    old_size_rd, new_size_rd;
   logic [TW-1:0]    old_stride_rd;
   logic [DW-1:0]    strides_rd, new_size_ext;
   logic             scan_last, emit_end, list_empty;

   logic          mul_start, mul_done;
   logic [DW-1:0] mul_a, mul_b, mul_p;

   // index arithmetic
   assign vd_m1      = vd_cnt_ff - CNT_W'(1);
   assign old_m1     = old_cnt_ff - CNT_W'(1);
   assign ptr_plus   = CNT_W'(ptr_ff) + CNT_W'(1);
   assign vd_idx     = vd_m1[IDX_W-1:0];
   assign old_wr_idx = old_cnt_ff[IDX_W-1:0];
   assign new_wr_idx = new_cnt_ff[IDX_W-1:0];
   assign new_rd_idx = (cmd.code == tvsc_pkg::DP_SCAN_STEP) ? ptr_ff : vd_idx;

   // one read port per list
   assign old_size_rd   = old_sizes_ff[ptr_ff];
   assign old_stride_rd = old_strides_ff[ptr_ff];
   assign new_size_rd   = new_sizes_ff[new_rd_idx];
   assign strides_rd    = strides_ff[ptr_ff];
   assign new_size_ext  = DW'(new_size_rd);

   assign scan_last  = (ptr_plus == old_cnt_ff);
   assign list_empty = (new_cnt_ff == '0);
   assign emit_end   = (cmd.kind == tvsc_pkg::KIND_FAIL) || list_empty ||
                       (ptr_plus == new_cnt_ff);

   // multiplier operand selection
   always_comb begin
      case (cmd.sel)
         tvsc_pkg::SEL_TEL_SIZE: begin
            mul_a = telems_ff;
            mul_b = DW'(old_size_rd);
         end
         tvsc_pkg::SEL_TEL_BASE: begin
            mul_a = telems_ff;
            mul_b = DW'(base_ff);
         end
         tvsc_pkg::SEL_VEL_BASE: begin
            mul_a = velems_ff;
            mul_b = DW'(base_ff);
         end
         tvsc_pkg::SEL_VEL_NEW: begin
            mul_a = velems_ff;
            mul_b = new_size_ext;
         end
         tvsc_pkg::SEL_VEL_NEW1: begin
            mul_a = velems_ff;
            mul_b = (new_size_rd == '0) ? DW'(1) : new_size_ext;
         end
         default: begin
            mul_a = telems_ff;
            mul_b = DW'(old_size_rd);
         end
      endcase
   end

   assign mul_start = (cmd.code == tvsc_pkg::DP_MUL);

   tvsc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   // command execution
   always_comb begin
      old_cnt_in      = old_cnt_ff;
      new_cnt_in      = new_cnt_ff;
      vd_cnt_in       = vd_cnt_ff;
      ptr_in          = ptr_ff;
      ovf_in          = ovf_ff;
      any_zero_in     = any_zero_ff;
      same_in         = same_ff;
      last_dim_in     = last_dim_ff;
      base_in         = base_ff;
      telems_in       = telems_ff;
      velems_in       = velems_ff;
      old_wr_en       = 1'b0;
      new_wr_en       = 1'b0;
      strides_wr_en   = 1'b0;
      strides_wr_data = velems_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_ok_in       = rsp_ok_ff;
      rsp_no_dims_in  = rsp_no_dims_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_stride_in   = rsp_stride_ff;
      rsp_end_in      = rsp_end_ff;

      case (cmd.code)
         tvsc_pkg::DP_APPEND_OLD: begin
            if (old_cnt_ff < CNT_W'(MAX_RANK)) begin
               old_wr_en  = 1'b1;
               old_cnt_in = old_cnt_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         tvsc_pkg::DP_APPEND_NEW: begin
            if (new_cnt_ff < CNT_W'(MAX_RANK)) begin
               new_wr_en  = 1'b1;
               new_cnt_in = new_cnt_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         tvsc_pkg::DP_SCAN_INIT: begin
            ptr_in      = '0;
            any_zero_in = 1'b0;
            same_in     = (old_cnt_ff == new_cnt_ff);
         end
         tvsc_pkg::DP_SCAN_STEP: begin
            any_zero_in = any_zero_ff || (old_size_rd == '0);
            same_in     = same_ff && (old_size_rd == new_size_rd);
            if (!scan_last) begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         tvsc_pkg::DP_PTR_LAST: begin
            ptr_in    = old_m1[IDX_W-1:0];
            vd_cnt_in = new_cnt_ff;
         end
         tvsc_pkg::DP_LOAD_BASE: begin
            base_in   = old_stride_rd;
            telems_in = DW'(1);
            velems_in = DW'(1);
         end
         tvsc_pkg::DP_TEL_WB: begin
            telems_in   = mul_p;
            last_dim_in = (ptr_ff == '0);
            if (ptr_ff != '0) begin
               ptr_in = ptr_ff - IDX_W'(1);
            end
         end
         tvsc_pkg::DP_BUF_WR: begin
            strides_wr_en   = 1'b1;
            strides_wr_data = mul_p;
         end
         tvsc_pkg::DP_BUF_ACC: begin
            strides_wr_en = 1'b1;
         end
         tvsc_pkg::DP_VEL_WB: begin
            velems_in = mul_p;
            vd_cnt_in = vd_m1;
         end
         tvsc_pkg::DP_CONTIG_INIT: begin
            vd_cnt_in = new_cnt_ff;
            velems_in = DW'(1);
         end
         tvsc_pkg::DP_PTR_ZERO: begin
            ptr_in = '0;
         end
         tvsc_pkg::DP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_end_in   = emit_end;
            if (cmd.kind == tvsc_pkg::KIND_FAIL) begin
               rsp_ok_in      = 1'b0;
               rsp_no_dims_in = 1'b0;
               rsp_index_in   = '0;
               rsp_stride_in  = '0;
            end else if (list_empty) begin
               rsp_ok_in      = 1'b1;
               rsp_no_dims_in = 1'b1;
               rsp_index_in   = '0;
               rsp_stride_in  = '0;
            end else begin
               rsp_ok_in      = 1'b1;
               rsp_no_dims_in = 1'b0;
               rsp_index_in   = tvsc_pkg::DIM_INDEX_W'(ptr_ff);
               case (cmd.kind)
                  tvsc_pkg::KIND_ONES: rsp_stride_in = DW'(1);
                  tvsc_pkg::KIND_OLD:  rsp_stride_in = DW'(old_stride_rd);
                  default:             rsp_stride_in = strides_rd;
               endcase
            end
            // last transfer of a compute clears both lists
            if (emit_end) begin
               old_cnt_in = '0;
               new_cnt_in = '0;
               ovf_in     = 1'b0;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // list storage
   always_ff @(posedge clock) begin
      if (old_wr_en) begin
         old_sizes_ff[old_wr_idx]   <= dim_size;
         old_strides_ff[old_wr_idx] <= dim_stride;
      end
      if (new_wr_en) begin
         new_sizes_ff[new_wr_idx] <= dim_size;
      end
      if (strides_wr_en) begin
         strides_ff[vd_idx] <= strides_wr_data;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      vd_cnt_ff      <= vd_cnt_in;
      ptr_ff         <= ptr_in;
      any_zero_ff    <= any_zero_in;
      same_ff        <= same_in;
      last_dim_ff    <= last_dim_in;
      base_ff        <= base_in;
      telems_ff      <= telems_in;
      velems_ff      <= velems_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_no_dims_ff <= rsp_no_dims_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_stride_ff  <= rsp_stride_in;
      rsp_end_ff     <= rsp_end_in;
      if (reset) begin
         old_cnt_ff   <= '0;
         new_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         old_cnt_ff   <= old_cnt_in;
         new_cnt_ff   <= new_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status to the controller
   always_comb begin
      sts.ovf        = ovf_ff;
      sts.old_zero   = (old_cnt_ff == '0);
      sts.scan_last  = scan_last;
      sts.any_zero   = any_zero_ff;
      sts.same       = same_ff;
      sts.last_dim   = last_dim_ff;
      sts.cur_one    = (old_size_rd == SW'(1));
      sts.vd_valid   = (vd_cnt_ff != '0);
      sts.vd_one     = (vd_cnt_ff == CNT_W'(1));
      sts.lt_vt      = ($signed(velems_ff) < $signed(telems_ff));
      sts.new_one    = (vd_cnt_ff != '0) && (new_size_rd == SW'(1));
      sts.vel_eq_tel = (velems_ff == telems_ff);
      sts.mul_done   = mul_done;
      sts.stride_ne  = (mul_p != DW'(old_stride_rd));
      sts.out_free   = !rsp_valid_ff || rsp.ready;
      sts.emit_end   = emit_end;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ok          = rsp_ok_ff;
   assign rsp.no_dims     = rsp_no_dims_ff;
   assign rsp.dim_index   = rsp_index_ff;
   assign rsp.stride_out  = rsp_stride_ff;
   assign rsp.end_of_list = rsp_end_ff;

endmodule

// ===== src/tvsc_ctrl.sv =====
module tvsc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [tvsc_pkg::OP_W-1:0] req_op,
   output logic                      req_ready,
   output tvsc_pkg::dp_cmd_type      cmd,
   input  tvsc_pkg::dp_sts_type      sts
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SCAN_DONE,
      ST_CONTIG_WR,
      ST_CONTIG_MUL,
      ST_CONTIG_WAIT,
      ST_BASE,
      ST_TEL_MUL,
      ST_TEL_WAIT,
      ST_CHK,
      ST_CHK_WAIT,
      ST_GRP,
      ST_GRP_W1,
      ST_GRP_M2,
      ST_GRP_W2,
      ST_EMIT_SETUP,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   tvsc_pkg::emit_kind_type kind_ff, kind_in;

   // sequencing of the stride walk
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd.code  = tvsc_pkg::DP_NOP;
      cmd.sel   = tvsc_pkg::SEL_TEL_SIZE;
      cmd.kind  = kind_ff;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  tvsc_pkg::OP_APPEND_OLD: cmd.code = tvsc_pkg::DP_APPEND_OLD;
                  tvsc_pkg::OP_APPEND_NEW: cmd.code = tvsc_pkg::DP_APPEND_NEW;
                  tvsc_pkg::OP_COMPUTE:    state_in = ST_CHECK;
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            cmd.code = tvsc_pkg::DP_SCAN_INIT;
            if (sts.ovf) begin
               kind_in  = tvsc_pkg::KIND_FAIL;
               state_in = ST_EMIT_SETUP;
            end else if (sts.old_zero) begin
               kind_in  = tvsc_pkg::KIND_ONES;
               state_in = ST_EMIT_SETUP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.code = tvsc_pkg::DP_SCAN_STEP;
            if (sts.scan_last) begin
               state_in = ST_SCAN_DONE;
            end
         end
         ST_SCAN_DONE: begin
            kind_in = tvsc_pkg::KIND_BUF;
            if (sts.any_zero && sts.same) begin
               kind_in  = tvsc_pkg::KIND_OLD;
               state_in = ST_EMIT_SETUP;
            end else if (sts.any_zero) begin
               cmd.code = tvsc_pkg::DP_CONTIG_INIT;
               state_in = ST_CONTIG_WR;
            end else begin
               cmd.code = tvsc_pkg::DP_PTR_LAST;
               state_in = ST_BASE;
            end
         end
         // contiguous strides, innermost first
         ST_CONTIG_WR: begin
            if (!sts.vd_valid) begin
               state_in = ST_EMIT_SETUP;
            end else begin
               cmd.code = tvsc_pkg::DP_BUF_ACC;
               state_in = sts.vd_one ? ST_EMIT_SETUP : ST_CONTIG_MUL;
            end
         end
         ST_CONTIG_MUL: begin
            cmd.code = tvsc_pkg::DP_MUL;
            cmd.sel  = tvsc_pkg::SEL_VEL_NEW1;
            state_in = ST_CONTIG_WAIT;
         end
         ST_CONTIG_WAIT: begin
            if (sts.mul_done) begin
               cmd.code = tvsc_pkg::DP_VEL_WB;
               state_in = ST_CONTIG_WR;
            end
         end
         // group of contiguous old dimensions
         ST_BASE: begin
            cmd.code = tvsc_pkg::DP_LOAD_BASE;
            state_in = ST_TEL_MUL;
         end
         ST_TEL_MUL: begin
            cmd.code = tvsc_pkg::DP_MUL;
            cmd.sel  = tvsc_pkg::SEL_TEL_SIZE;
            state_in = ST_TEL_WAIT;
         end
         ST_TEL_WAIT: begin
            if (sts.mul_done) begin
               cmd.code = tvsc_pkg::DP_TEL_WB;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.last_dim) begin
               state_in = ST_GRP;
            end else if (sts.cur_one) begin
               state_in = ST_TEL_MUL;
            end else begin
               cmd.code = tvsc_pkg::DP_MUL;
               cmd.sel  = tvsc_pkg::SEL_TEL_BASE;
               state_in = ST_CHK_WAIT;
            end
         end
         ST_CHK_WAIT: begin
            if (sts.mul_done) begin
               state_in = sts.stride_ne ? ST_GRP : ST_TEL_MUL;
            end
         end
         // match new dimensions against the finished group
         ST_GRP: begin
            if (sts.vd_valid && (sts.lt_vt || sts.new_one)) begin
               cmd.code = tvsc_pkg::DP_MUL;
               cmd.sel  = tvsc_pkg::SEL_VEL_BASE;
               state_in = ST_GRP_W1;
            end else if (!sts.vel_eq_tel) begin
               kind_in  = tvsc_pkg::KIND_FAIL;
               state_in = ST_EMIT_SETUP;
            end else if (sts.last_dim) begin
               kind_in  = sts.vd_valid ? tvsc_pkg::KIND_FAIL : tvsc_pkg::KIND_BUF;
               state_in = ST_EMIT_SETUP;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_GRP_W1: begin
            if (sts.mul_done) begin
               cmd.code = tvsc_pkg::DP_BUF_WR;
               state_in = ST_GRP_M2;
            end
         end
         ST_GRP_M2: begin
            cmd.code = tvsc_pkg::DP_MUL;
            cmd.sel  = tvsc_pkg::SEL_VEL_NEW;
            state_in = ST_GRP_W2;
         end
         ST_GRP_W2: begin
            if (sts.mul_done) begin
               cmd.code = tvsc_pkg::DP_VEL_WB;
               state_in = ST_GRP;
            end
         end
         // result transfers
         ST_EMIT_SETUP: begin
            cmd.code = tvsc_pkg::DP_PTR_ZERO;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.code = tvsc_pkg::DP_EMIT;
               if (sts.emit_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= tvsc_pkg::KIND_FAIL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== src/tensor_view_stride_calc.sv =====
// Channel    Dir  Transfer when       Payload
// req_chan   in   valid && ready      op, dim_size, dim_stride
// rsp_chan   out  valid && ready      ok, no_dims, dim_index, stride_out, end_of_list
//
// A load (op 0 or 1) is taken in the idle state. A compute runs setup and a scan of the
// old dimensions and a walk over old and new dimensions, mostly spent on the shared
// 64-bit multiplier (three 32x32 partial products), then a setup step and the results.
// Reset is synchronous and active high; it empties both lists. A last result may
// wait in the result register while new loads are taken.
module tensor_view_stride_calc #(
   parameter int MAX_RANK = 8
) (
   input logic        clock,
   input logic        reset,
   tvsc_req_if.sink   req_chan,
   tvsc_rsp_if.source rsp_chan
);

   tvsc_pkg::dp_cmd_type cmd;
   tvsc_pkg::dp_sts_type sts;
   logic                 ready;

   tvsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tvsc_dp #(
      .MAX_RANK (MAX_RANK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .dim_size   (req_chan.dim_size),
      .dim_stride (req_chan.dim_stride),
      .rsp        (rsp_chan)
   );

   assign req_chan.ready = ready;

endmodule

// ===== src/tvsc_checker.sv =====
module tvsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [tvsc_pkg::OP_W-1:0]        req_op,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_ok,
   input logic                             rsp_no_dims,
   input logic [tvsc_pkg::DIM_INDEX_W-1:0] rsp_dim_index,
   input logic [tvsc_pkg::DATA_W-1:0]      rsp_stride_out,
   input logic                             rsp_end_of_list
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stride_out) &&
                                  $stable(rsp_dim_index) && $stable(rsp_end_of_list))
      else $error("stalled result changed");

   // an empty success is a lone, closing result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_dims |-> rsp_ok && rsp_end_of_list &&
                                   rsp_dim_index == '0 && rsp_stride_out == '0)
      else $error("empty-shape result malformed");

   // a failure is a lone, closing result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_end_of_list && !rsp_no_dims &&
                               rsp_dim_index == '0 && rsp_stride_out == '0)
      else $error("failure result malformed");

   // a compute transfer closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == tvsc_pkg::OP_COMPUTE |=> !req_ready)
      else $error("request taken during compute");

endmodule

bind tensor_view_stride_calc tvsc_checker u_tvsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_op          (req_chan.op),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_ok          (rsp_chan.ok),
   .rsp_no_dims     (rsp_chan.no_dims),
   .rsp_dim_index   (rsp_chan.dim_index),
   .rsp_stride_out  (rsp_chan.stride_out),
   .rsp_end_of_list (rsp_chan.end_of_list)
);
